// File: rtl/rlpq_pkg.sv
// ----------------------------------------------------------------------------
// rlpq_pkg
// Shared types and constants of the rate limited priority queue.
// ----------------------------------------------------------------------------
package rlpq_pkg;

  // Default number of queue slots
  localparam int unsigned QueueDepthDflt = 8;

  // Field widths
  localparam int unsigned HandleW   = 16;
  localparam int unsigned PrioW     = 8;
  localparam int unsigned TimeW     = 32;
  localparam int unsigned IntervalW = 16;
  localparam int unsigned OccW      = 4;
  localparam int unsigned StatusW   = 3;

  // Stream payload widths (whole bytes)
  localparam int unsigned InDataW  = 56;
  localparam int unsigned OutDataW = 24;

  // Interval register value after reset
  localparam logic [IntervalW-1:0] SendIntervalRst = 16'd1000;

  // Request kind
  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_POLL = 1'b1
  } cmd_e;

  // Result status
  typedef enum logic [StatusW-1:0] {
    STAT_QUEUED  = 3'd0,
    STAT_DROPPED = 3'd1,
    STAT_EMPTY   = 3'd2,
    STAT_EARLY   = 3'd3,
    STAT_SENT    = 3'd4
  } status_e;

  // Controller states
  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic load_in;  // capture the incoming request
    logic commit;   // update the queue and load the result register
  } ctrl_t;

endpackage

// File: rtl/rlpq_ctrl.sv
// ----------------------------------------------------------------------------
// rlpq_ctrl
// Request sequencer: accepts a request, commits it once the result register
// is free, and tracks the output valid flag.
// ----------------------------------------------------------------------------
module rlpq_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_axis_tvalid_i,
  output logic           s_axis_tready_o,
  output logic           m_axis_tvalid_o,
  input  logic           m_axis_tready_i,
  output rlpq_pkg::ctrl_t ctrl_o
);

  rlpq_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;
  logic             out_free;

  // Result register can take a new result this cycle
  assign out_free = !out_valid_q || m_axis_tready_i;

  // State and output valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rlpq_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d        = state_q;
    ctrl_o.load_in = 1'b0;
    ctrl_o.commit  = 1'b0;
    out_valid_d    = out_valid_q && !m_axis_tready_i;
    s_axis_tready_o = 1'b0;
    unique case (state_q)
      rlpq_pkg::S_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) begin
          ctrl_o.load_in = 1'b1;
          state_d        = rlpq_pkg::S_EXEC;
        end
      end
      rlpq_pkg::S_EXEC: begin
        if (out_free) begin
          ctrl_o.commit = 1'b1;
          out_valid_d   = 1'b1;
          state_d       = rlpq_pkg::S_IDLE;
        end
      end
      default: state_d = rlpq_pkg::S_IDLE;
    endcase
  end

  assign m_axis_tvalid_o = out_valid_q;

endmodule

// File: rtl/rlpq_datapath.sv
// ----------------------------------------------------------------------------
// rlpq_datapath
// Sorted slot registers with parallel priority compare, send interval timer
// and the result register.
// ----------------------------------------------------------------------------
module rlpq_datapath #(
  parameter int unsigned QUEUE_DEPTH = rlpq_pkg::QueueDepthDflt
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  rlpq_pkg::ctrl_t                   ctrl_i,
  input  logic                              cfg_we_i,
  input  logic [rlpq_pkg::IntervalW-1:0]    cfg_wdata_i,
  input  logic [rlpq_pkg::InDataW-1:0]      s_axis_tdata_i,
  input  logic                              s_axis_tuser_i,
  output logic [rlpq_pkg::OutDataW-1:0]     m_axis_tdata_o,
  output logic [rlpq_pkg::StatusW-1:0]      m_axis_tuser_o
);

  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned Tail = QUEUE_DEPTH - 1;

  // Captured request
  rlpq_pkg::cmd_e                  in_cmd_q;
  logic [rlpq_pkg::HandleW-1:0]    in_handle_q;
  logic [rlpq_pkg::PrioW-1:0]      in_prio_q;
  logic [rlpq_pkg::TimeW-1:0]      in_now_q;

  // Queue state
  logic [rlpq_pkg::HandleW-1:0]    handle_q [QUEUE_DEPTH];
  logic [rlpq_pkg::HandleW-1:0]    handle_d [QUEUE_DEPTH];
  logic [rlpq_pkg::PrioW-1:0]      prio_q   [QUEUE_DEPTH];
  logic [rlpq_pkg::PrioW-1:0]      prio_d   [QUEUE_DEPTH];
  logic [CntW-1:0]                 count_q, count_d;
  logic [rlpq_pkg::TimeW-1:0]      last_send_q, last_send_d;
  logic [rlpq_pkg::IntervalW-1:0]  interval_q;

  // Result register
  rlpq_pkg::status_e               out_status_q, res_status;
  logic [rlpq_pkg::HandleW-1:0]    out_handle_q, res_handle;
  logic [rlpq_pkg::OccW-1:0]       out_occ_q;

  // Decode
  logic [QUEUE_DEPTH-1:0]          lt;
  logic [QUEUE_DEPTH-1:0]          ins_before;
  logic [rlpq_pkg::TimeW-1:0]      elapsed;
  logic                            full, drop, early, empty;
  logic                            push_do, pop_do;

  // Capture request fields
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_in) begin
      in_cmd_q    <= rlpq_pkg::cmd_e'(s_axis_tuser_i);
      in_handle_q <= s_axis_tdata_i[15:0];
      in_prio_q   <= s_axis_tdata_i[23:16];
      in_now_q    <= s_axis_tdata_i[55:24];
    end
  end

  // Compare the new priority against every occupied slot at once
  always_comb begin
    logic [QUEUE_DEPTH-1:0] low_mask;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      lt[i] = (CntW'(i) < count_q) && (prio_q[i] < in_prio_q);
    end
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      low_mask      = {QUEUE_DEPTH{1'b1}} >> (QUEUE_DEPTH - 1 - i);
      ins_before[i] = |(lt & low_mask);
    end
  end

  assign full    = (count_q == CntW'(QUEUE_DEPTH));
  assign drop    = full && !(prio_q[Tail] < in_prio_q);
  assign empty   = (count_q == '0);
  assign elapsed = in_now_q - last_send_q;
  assign early   = elapsed < {{(rlpq_pkg::TimeW - rlpq_pkg::IntervalW){1'b0}}, interval_q};

  assign push_do = ctrl_i.commit && (in_cmd_q == rlpq_pkg::CMD_PUSH) && !drop;
  assign pop_do  = ctrl_i.commit && (in_cmd_q == rlpq_pkg::CMD_POLL) && !empty && !early;

  // Result selection
  always_comb begin
    res_handle = '0;
    if (in_cmd_q == rlpq_pkg::CMD_PUSH) begin
      res_status = drop ? rlpq_pkg::STAT_DROPPED : rlpq_pkg::STAT_QUEUED;
    end else if (empty) begin
      res_status = rlpq_pkg::STAT_EMPTY;
    end else if (early) begin
      res_status = rlpq_pkg::STAT_EARLY;
    end else begin
      res_status = rlpq_pkg::STAT_SENT;
      res_handle = handle_q[0];
    end
  end

  // Next slot contents: shift up on insert, shift down on pop
  always_comb begin
    count_d     = count_q;
    last_send_d = last_send_q;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      handle_d[i] = handle_q[i];
      prio_d[i]   = prio_q[i];
    end
    if (push_do) begin
      if (!full) begin
        count_d = count_q + CntW'(1);
      end
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        if (i > 0 && ins_before[(i > 0) ? i - 1 : 0]) begin
          handle_d[i] = handle_q[(i > 0) ? i - 1 : 0];
          prio_d[i]   = prio_q[(i > 0) ? i - 1 : 0];
        end else if (lt[i] || (!ins_before[Tail] && CntW'(i) == count_q)) begin
          handle_d[i] = in_handle_q;
          prio_d[i]   = in_prio_q;
        end
      end
    end else if (pop_do) begin
      count_d     = count_q - CntW'(1);
      last_send_d = in_now_q;
      for (int i = 0; i < Tail; i++) begin
        handle_d[i] = handle_q[i + 1];
        prio_d[i]   = prio_q[i + 1];
      end
    end
  end

  // Slot payload
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      handle_q[i] <= handle_d[i];
      prio_q[i]   <= prio_d[i];
    end
  end

  // Control state and interval register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      last_send_q <= '0;
      interval_q  <= rlpq_pkg::SendIntervalRst;
    end else begin
      count_q     <= count_d;
      last_send_q <= last_send_d;
      if (cfg_we_i) begin
        interval_q <= cfg_wdata_i;
      end
    end
  end

  // Load result register
  always_ff @(posedge clk_i) begin
    if (ctrl_i.commit) begin
      out_status_q <= res_status;
      out_handle_q <= res_handle;
      out_occ_q    <= rlpq_pkg::OccW'(count_d);
    end
  end

  assign m_axis_tdata_o = {4'd0, out_occ_q, out_handle_q};
  assign m_axis_tuser_o = out_status_q;

  // Fill level never passes the slot count
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(QUEUE_DEPTH))
    else $error("entry count above queue depth");

  // A dropped push leaves the fill level alone
  a_drop_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.commit && res_status == rlpq_pkg::STAT_DROPPED) |=> $stable(count_q))
    else $error("dropped push changed the queue");

  // A send removes exactly one entry
  a_send_pops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.commit && res_status == rlpq_pkg::STAT_SENT)
      |=> (count_q == $past(count_q) - CntW'(1)))
    else $error("send did not remove one entry");

endmodule

// File: rtl/rate_limited_priority_queue.sv
// ----------------------------------------------------------------------------
// rate_limited_priority_queue
// Bounded priority queue, sorted by descending priority, with a minimum
// interval between sends.
// ----------------------------------------------------------------------------
// Each request (push or poll) is captured in S_IDLE, then S_EXEC compares
// the new priority against all slots in parallel and updates the sorted slot
// registers; only then is the next request taken. A waiting result does not
// block the capture of the next request; the update waits only while the
// result is held by m_axis_tready_i low. Pushes into a full queue evict the
// tail when the new priority is strictly higher, otherwise they are dropped.
// A poll sends the head once (now_ms - last send time) modulo 2^32 reaches
// send_interval_ms (reset 1000), written through cfg_we_i / cfg_wdata_i; the
// user must write it only while idle; the block does not check this.
module rate_limited_priority_queue #(
  parameter int unsigned QUEUE_DEPTH = rlpq_pkg::QueueDepthDflt
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration: send_interval_ms
  input  logic                           cfg_we_i,
  input  logic [rlpq_pkg::IntervalW-1:0] cfg_wdata_i,
  // Request stream
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // [15:0] msg_handle, [23:16] msg_priority, [55:24] now_ms
  input  logic [rlpq_pkg::InDataW-1:0]   s_axis_tdata_i,
  // [0] cmd (0 push, 1 poll)
  input  logic                           s_axis_tuser_i,
  // Result stream
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // [15:0] sent_handle, [19:16] occupancy, [23:20] zero
  output logic [rlpq_pkg::OutDataW-1:0]  m_axis_tdata_o,
  // [2:0] status
  output logic [rlpq_pkg::StatusW-1:0]   m_axis_tuser_o
);

  rlpq_pkg::ctrl_t ctrl;

  // Sequencer
  rlpq_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .ctrl_o          (ctrl)
  );

  // Queue datapath
  rlpq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (ctrl),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the rate limited priority queue. Requests (pushes
// and polls) are driven on the input stream with random gaps, and results
// are taken with random back-pressure. A sorted-queue model predicts each
// result, and a scoreboard compares it field by field. The send interval is
// reprogrammed between phases, including zero and the largest value.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned DEPTH = rlpq_pkg::QueueDepthDflt;

  // One predicted result
  typedef struct {
    rlpq_pkg::status_e                  status;
    logic [rlpq_pkg::HandleW-1:0]       handle;
    logic [rlpq_pkg::OccW-1:0]          occ;
  } reply_t;

  // Sorted queue model plus the list of results still owed by the block
  class queue_tracker;
    logic [rlpq_pkg::HandleW-1:0]   held_handle [DEPTH];
    logic [rlpq_pkg::PrioW-1:0]     held_prio   [DEPTH];
    int unsigned                    held_count;
    logic [rlpq_pkg::TimeW-1:0]     last_sent_ms;
    logic [rlpq_pkg::IntervalW-1:0] interval_ms;
    reply_t                         awaited [$];
    int unsigned                    mismatches;

    function new();
      held_count   = 0;
      last_sent_ms = '0;
      interval_ms  = rlpq_pkg::SendIntervalRst;
      mismatches   = 0;
    endfunction

    // Predict the result of one accepted request and update the model
    function void log_request(rlpq_pkg::cmd_e cmd, logic [rlpq_pkg::HandleW-1:0] handle,
                              logic [rlpq_pkg::PrioW-1:0] prio,
                              logic [rlpq_pkg::TimeW-1:0] now);
      reply_t                     r;
      int unsigned                pos;
      logic [rlpq_pkg::TimeW-1:0] elapsed;
      r.handle = '0;
      elapsed  = now - last_sent_ms;
      if (cmd == rlpq_pkg::CMD_PUSH) begin
        if (held_count == DEPTH && held_prio[DEPTH-1] >= prio) begin
          r.status = rlpq_pkg::STAT_DROPPED;
        end else begin
          r.status = rlpq_pkg::STAT_QUEUED;
          // evict the tail to make room
          if (held_count == DEPTH) held_count--;
          // entries below the new priority form a suffix; find its start
          pos = held_count;
          for (int unsigned i = held_count; i > 0; i--) begin
            if (held_prio[i-1] < prio) pos = i - 1;
          end
          for (int unsigned i = held_count; i > pos; i--) begin
            held_handle[i] = held_handle[i-1];
            held_prio[i]   = held_prio[i-1];
          end
          held_handle[pos] = handle;
          held_prio[pos]   = prio;
          held_count++;
        end
      end else if (held_count == 0) begin
        r.status = rlpq_pkg::STAT_EMPTY;
      end else if (elapsed < rlpq_pkg::TimeW'(interval_ms)) begin
        r.status = rlpq_pkg::STAT_EARLY;
      end else begin
        // pop the head
        r.status     = rlpq_pkg::STAT_SENT;
        r.handle     = held_handle[0];
        last_sent_ms = now;
        for (int unsigned i = 0; i + 1 < held_count; i++) begin
          held_handle[i] = held_handle[i+1];
          held_prio[i]   = held_prio[i+1];
        end
        held_count--;
      end
      r.occ = rlpq_pkg::OccW'(held_count);
      awaited.push_back(r);
    endfunction

    // Compare one result against the oldest prediction
    function void match_result(logic [rlpq_pkg::StatusW-1:0] status,
                               logic [rlpq_pkg::HandleW-1:0] handle,
                               logic [rlpq_pkg::OccW-1:0] occ, logic [3:0] pad);
      reply_t exp;
      if (awaited.size() == 0) begin
        $display("%0t: result with nothing expected, status %0d handle %0h occupancy %0d",
                 $time, status, handle, occ);
        mismatches++;
        return;
      end
      exp = awaited.pop_front();
      if (status !== exp.status) begin
        $display("%0t: status mismatch, expected %0d, actual %0d", $time, exp.status, status);
        mismatches++;
      end
      if (handle !== exp.handle) begin
        $display("%0t: sent_handle mismatch, expected %0h, actual %0h",
                 $time, exp.handle, handle);
        mismatches++;
      end
      if (occ !== exp.occ) begin
        $display("%0t: occupancy mismatch, expected %0d, actual %0d", $time, exp.occ, occ);
        mismatches++;
      end
      if (pad !== 4'h0) begin
        $display("%0t: pad bits mismatch, expected 0, actual %0h", $time, pad);
        mismatches++;
      end
    endfunction
  endclass

  logic                           clk_i;
  logic                           rst_ni    = 1'b0;
  logic                           cfg_we    = 1'b0;
  logic [rlpq_pkg::IntervalW-1:0] cfg_wdata = '0;
  logic                           req_valid = 1'b0;
  logic                           req_ready;
  logic [rlpq_pkg::InDataW-1:0]   req_data  = '0;
  logic                           req_cmd   = 1'b0;
  logic                           rsp_valid;
  logic                           rsp_ready = 1'b0;
  logic [rlpq_pkg::OutDataW-1:0]  rsp_data;
  logic [rlpq_pkg::StatusW-1:0]   rsp_status;

  queue_tracker                   tracker;
  bit                             calm = 1'b0;
  logic [rlpq_pkg::TimeW-1:0]     clock_ms;
  int unsigned                    push_pct;

  rate_limited_priority_queue #(
    .QUEUE_DEPTH(DEPTH)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .s_axis_tvalid_i(req_valid),
    .s_axis_tready_o(req_ready),
    .s_axis_tdata_i (req_data),
    .s_axis_tuser_i (req_cmd),
    .m_axis_tvalid_o(rsp_valid),
    .m_axis_tready_i(rsp_ready),
    .m_axis_tdata_o (rsp_data),
    .m_axis_tuser_o (rsp_status)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Idle roll: true with a chance of 8 in 100, never during a calm stretch
  function automatic bit idle_roll();
    return !calm && ($urandom_range(0, 99) < 8);
  endfunction

  // Result side back-pressure
  always @(negedge clk_i) begin
    rsp_ready = rst_ni && !idle_roll();
  end

  // Note each accepted request
  always @(posedge clk_i) begin
    if (rst_ni && req_valid && req_ready) begin
      tracker.log_request(rlpq_pkg::cmd_e'(req_cmd), req_data[15:0], req_data[23:16],
                          req_data[55:24]);
    end
  end

  // Check each accepted result
  always @(posedge clk_i) begin
    if (rst_ni && rsp_valid && rsp_ready) begin
      tracker.match_result(rsp_status, rsp_data[15:0], rsp_data[19:16], rsp_data[23:20]);
    end
  end

  // Offer one request and hold it until taken; starts and ends at a falling edge
  task automatic drive_request(rlpq_pkg::cmd_e cmd, logic [rlpq_pkg::HandleW-1:0] handle,
                               logic [rlpq_pkg::PrioW-1:0] prio,
                               logic [rlpq_pkg::TimeW-1:0] now);
    while (idle_roll()) begin
      req_valid = 1'b0;
      @(negedge clk_i);
    end
    req_valid = 1'b1;
    req_cmd   = cmd;
    req_data  = {now, prio, handle};
    do @(posedge clk_i); while (!req_ready);
    @(negedge clk_i);
  endtask

  // Push with a random, unused time field
  task automatic push_msg(logic [rlpq_pkg::HandleW-1:0] handle,
                          logic [rlpq_pkg::PrioW-1:0] prio);
    drive_request(rlpq_pkg::CMD_PUSH, handle, prio, $urandom);
  endtask

  // Poll with random, unused handle and priority fields
  task automatic poll_at(logic [rlpq_pkg::TimeW-1:0] now);
    drive_request(rlpq_pkg::CMD_POLL, rlpq_pkg::HandleW'($urandom),
                  rlpq_pkg::PrioW'($urandom), now);
  endtask

  // Reprogram the interval once the block has drained
  task automatic write_interval(logic [rlpq_pkg::IntervalW-1:0] value);
    req_valid = 1'b0;
    while (tracker.awaited.size() != 0) @(negedge clk_i);
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(negedge clk_i);
    cfg_we    = 1'b0;
    tracker.interval_ms = value;
  endtask

  // One random request: pushes with clustered priorities, polls on a moving clock
  task automatic random_request();
    int unsigned span;
    if ($urandom_range(0, 99) < push_pct) begin
      if ($urandom_range(0, 1) == 0) begin
        push_msg(rlpq_pkg::HandleW'($urandom), rlpq_pkg::PrioW'($urandom_range(0, 3)));
      end else begin
        push_msg(rlpq_pkg::HandleW'($urandom), rlpq_pkg::PrioW'($urandom_range(0, 255)));
      end
    end else begin
      span = tracker.interval_ms + tracker.interval_ms / 2 + 2;
      // jump the clock anywhere now and then, wrap included
      if ($urandom_range(0, 9) == 0) clock_ms = $urandom;
      else                           clock_ms = clock_ms + $urandom_range(0, span);
      poll_at(clock_ms);
    end
  endtask

  // Stimulus
  initial begin
    logic [rlpq_pkg::IntervalW-1:0] phase_interval [5];
    tracker  = new();
    push_pct = 50;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: empty poll, ties, early poll, full queue, wrapped time
    poll_at(32'd0);
    push_msg(16'h0000, 8'd0);
    push_msg(16'hFFFF, 8'd255);
    push_msg(16'h0001, 8'd255);
    push_msg(16'h0002, 8'd128);
    poll_at(32'd500);
    poll_at(32'd1000);
    push_msg(16'h0003, 8'd1);
    push_msg(16'h0004, 8'd2);
    push_msg(16'h0005, 8'd3);
    push_msg(16'h0006, 8'd128);
    push_msg(16'h0007, 8'd0);
    push_msg(16'h0008, 8'd0);
    push_msg(16'h0009, 8'd200);
    poll_at(32'd1999);
    poll_at(32'd2000);
    poll_at(32'hFFFF_FFFF);
    poll_at(32'd998);
    poll_at(32'd999);

    // Random phases across interval settings, extremes included
    phase_interval[0] = '0;
    phase_interval[1] = '1;
    phase_interval[2] = 16'd1;
    phase_interval[3] = rlpq_pkg::IntervalW'($urandom_range(2, 5000));
    phase_interval[4] = rlpq_pkg::IntervalW'($urandom);
    clock_ms = 32'hFFFF_0000;
    for (int p = 0; p < 5; p++) begin
      write_interval(phase_interval[p]);
      calm = (p == 2);
      for (int n = 0; n < 160; n++) begin
        // swing between filling and draining
        if (n % 20 == 0) push_pct = $urandom_range(25, 75);
        random_request();
      end
    end
    calm = 1'b0;
    req_valid = 1'b0;

    while (tracker.awaited.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (tracker.mismatches == 0 && tracker.awaited.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Run limit
  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// File: files.f
rtl/rlpq_pkg.sv
rtl/rlpq_ctrl.sv
rtl/rlpq_datapath.sv
rtl/rate_limited_priority_queue.sv
bench/tb_top.sv
